[rtl/phx_pkg.sv]
// Shared constants and codes for the Philox4x32 counter generator.
`default_nettype none
package phx_pkg;

  localparam int unsigned PHX_ROUNDS_DEF = 10;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CTR_W   = 128;
  localparam int unsigned SKIP_W  = 64;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned OUT_W   = 128;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [WORD_W-1:0] PHX_MUL_A  = 32'hD2511F53;
  localparam logic [WORD_W-1:0] PHX_MUL_B  = 32'hCD9E8D57;
  localparam logic [WORD_W-1:0] PHX_WEYL_A = 32'h9E3779B9;
  localparam logic [WORD_W-1:0] PHX_WEYL_B = 32'hBB67AE85;

  typedef enum logic [MODE_W-1:0] {
    MODE_GEN    = 2'd0,
    MODE_SKIP   = 2'd1,
    MODE_RELOAD = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0     = 8'd0,
    REG_KEY1     = 8'd1,
    REG_START_LO = 8'd2,
    REG_START_HI = 8'd3
  } cfg_reg_e;

endpackage
`default_nettype wire

[rtl/philox_counter_rng_top.sv]
// Philox4x32 counter generator: one shared round unit under a round counter.
//
// Requests arrive on the s_axis channel: tuser carries the mode, tdata the
// skip count. A generate request copies the 128-bit block counter and the key
// into the round unit, which runs ROUNDS rounds (two 32x32 multipliers); the
// finish state then hands the block to the output register and bumps the counter.
// No new request is taken until a generate request's block has left the
// finish state; the result then shows on m_axis from the output register.
// Skip, reload and unused modes finish in the idle state and give no result.
// Results leave on m_axis as a 128-bit tdata held in an output register, so
// a new request is taken while the previous result still waits. If the
// receiver stalls and the register is still full when the next block
// finishes, the block waits in the round unit until the register frees.
// Configuration writes (key words, start counter) are taken every cycle on
// the cfg channel and must come only while the block is idle.
// Reset clears the counter, key, start counter, round unit and the output
// valid flag, and returns the sequencer to idle.
`default_nettype none
module philox_counter_rng_top #(
  parameter int unsigned ROUNDS = phx_pkg::PHX_ROUNDS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [phx_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [phx_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [phx_pkg::SKIP_W-1:0]     s_axis_tdata,   // [63:0] skip_count
  input  wire logic [phx_pkg::MODE_W-1:0]     s_axis_tuser,   // [1:0] mode
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [phx_pkg::OUT_W-1:0]           m_axis_tdata    // [63:0] word_low, [127:64] word_high
);
  import phx_pkg::*;

  localparam int unsigned RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  state_e              state_q;
  logic [RND_W-1:0]    rnd_q;
  logic [WORD_W-1:0]   w_q [4];
  logic [WORD_W-1:0]   ka_q, kb_q;
  logic [WORD_W-1:0]   key0_q, key1_q;
  logic [CTR_W-1:0]    start_q;
  logic [CTR_W-1:0]    ctr_q;
  logic [OUT_W-1:0]    out_q;
  logic                out_valid_q;

  logic [2*WORD_W-1:0] pa, pb;
  logic [WORD_W-1:0]   n0, n1, n2, n3;
  logic [SKIP_W-1:0]   add_amt;
  logic [SKIP_W:0]     sum_lo;
  logic [CTR_W-1:0]    ctr_sum;
  logic                in_acc, out_free, last_rnd;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign last_rnd = (rnd_q == RND_W'(ROUNDS - 1));

  // Round unit
  assign pa = 64'(w_q[0]) * 64'(PHX_MUL_A);
  assign pb = 64'(w_q[2]) * 64'(PHX_MUL_B);
  assign n0 = pb[2*WORD_W-1:WORD_W] ^ w_q[1] ^ ka_q;
  assign n1 = pb[WORD_W-1:0];
  assign n2 = pa[2*WORD_W-1:WORD_W] ^ w_q[3] ^ kb_q;
  assign n3 = pa[WORD_W-1:0];

  // Shared counter adder: skip count, or one after a block
  assign add_amt = (state_q == ST_FIN) ? SKIP_W'(1) : s_axis_tdata;
  assign sum_lo  = {1'b0, ctr_q[SKIP_W-1:0]} + {1'b0, add_amt};
  assign ctr_sum = {ctr_q[CTR_W-1:SKIP_W] + (CTR_W-SKIP_W)'(sum_lo[SKIP_W]),
                    sum_lo[SKIP_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      w_q         <= '{default: '0};
      ka_q        <= '0;
      kb_q        <= '0;
      key0_q      <= '0;
      key1_q      <= '0;
      start_q     <= '0;
      ctr_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_KEY0:     key0_q <= cfg_data_i[WORD_W-1:0];
          REG_KEY1:     key1_q <= cfg_data_i[WORD_W-1:0];
          REG_START_LO: start_q[SKIP_W-1:0] <= cfg_data_i;
          REG_START_HI: start_q[CTR_W-1:SKIP_W] <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (s_axis_tuser)
              MODE_GEN: begin
                w_q[0]  <= ctr_q[31:0];
                w_q[1]  <= ctr_q[63:32];
                w_q[2]  <= ctr_q[95:64];
                w_q[3]  <= ctr_q[127:96];
                ka_q    <= key0_q;
                kb_q    <= key1_q;
                rnd_q   <= '0;
                state_q <= ST_RUN;
              end
              MODE_SKIP:   ctr_q <= ctr_sum;
              MODE_RELOAD: ctr_q <= start_q;
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          w_q[0] <= n0;
          w_q[1] <= n1;
          w_q[2] <= n2;
          w_q[3] <= n3;
          ka_q   <= ka_q + PHX_WEYL_A;
          kb_q   <= kb_q + PHX_WEYL_B;
          rnd_q  <= rnd_q + RND_W'(1);
          if (last_rnd) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_q       <= {w_q[3], w_q[2], w_q[1], w_q[0]};
            out_valid_q <= 1'b1;
            ctr_q       <= ctr_sum;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/phx_checker.sv]
// Port-level checks for the Philox4x32 counter generator, bound to the top level.
`default_nettype none
module phx_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [phx_pkg::MODE_W-1:0]     s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [phx_pkg::OUT_W-1:0]      m_axis_tdata
);
  import phx_pkg::*;

  logic gen_acc, other_acc;
  assign gen_acc   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_GEN);
  assign other_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser != MODE_GEN);

  a_gen_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_acc |=> !s_axis_tready)
    else $error("ready high right after a generate request");

  a_other_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    other_acc |=> s_axis_tready)
    else $error("ready low after a skip, reload or unused request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind philox_counter_rng_top phx_checker u_phx_checker (.*);
`default_nettype wire
